>>> src/lphd_pkg.sv
// Package for the link packet header deframer.
// Holds result kinds, phase and type codes, queue sizing and the command record.
// No dependencies.
`default_nettype none

package lphd_pkg;

    // Command queue between the byte front end and the result back end
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_RAW_SIZE = 3'd1,
        KIND_RAW_TYPE = 3'd2,
        KIND_SHORT    = 3'd3,
        KIND_LONG     = 3'd4,
        KIND_VSIZE    = 3'd5,
        KIND_VTYPE    = 3'd6,
        KIND_PAYLOAD  = 3'd7
    } kind_t;

    // Byte position within a packet, counted from 1
    localparam logic [3:0] PH_FIRST   = 4'd1;
    localparam logic [3:0] PH_SIZE    = 4'd4;
    localparam logic [3:0] PH_TYPE    = 4'd5;
    localparam logic [3:0] PH_SHORT   = 4'd7;
    localparam logic [3:0] PH_LONG    = 4'd9;
    localparam logic [3:0] PH_VTYPE   = 4'd11;
    localparam logic [3:0] PH_PAYLOAD = 4'd12;

    // Raw packet types
    localparam logic [7:0] TYPE_LONG_A = 8'd1;
    localparam logic [7:0] TYPE_LONG_B = 8'd2;
    localparam logic [7:0] TYPE_SEQ    = 8'd3;
    localparam logic [7:0] TYPE_VIRT   = 8'd4;
    localparam logic [7:0] TYPE_SHORT  = 8'd5;

    // Countdown adjustments
    localparam logic [31:0] VHDR_BYTES = 32'd6;
    localparam logic [31:0] CONT_BYTES = 32'd4;
    localparam logic [31:0] ONE_BYTE   = 32'd1;

    // Sub-index of the final result of a continuation burst
    localparam logic [1:0] BURST_LAST = 2'd3;

    // One classified request for the back end
    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        packet_end;
        logic        burst;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/lphd_front.sv
// Front end of the deframer: accepts link bytes, tracks the packet phase and
// header fields, and emits one command per byte. Depends on lphd_pkg.
`default_nettype none

module lphd_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_data_byte,
    input  wire logic            q_full,
    output logic                 q_push,
    output lphd_pkg::cmd_t       q_cmd
);

    logic [3:0]  phase_reg, phase_next;
    logic [23:0] shift_reg;
    logic [31:0] remaining_reg, remaining_next;
    logic [7:0]  ptype_reg, ptype_next;
    logic [31:0] vsize_reg, vsize_next;
    logic        seq_start_reg, seq_start_next;
    logic [31:0] word32;
    logic [31:0] word16;
    logic [31:0] dec_amount;
    logic [31:0] remaining_dec;
    logic        is_long, is_vhdr, is_cont;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Header words end at the current byte
    assign word32 = {shift_reg, s_data_byte};
    assign word16 = {16'd0, shift_reg[7:0], s_data_byte};

    // Classify the type at the long-word position
    assign is_long = (ptype_reg == lphd_pkg::TYPE_LONG_A) ||
                     (ptype_reg == lphd_pkg::TYPE_LONG_B);
    assign is_vhdr = !is_long && ((ptype_reg == lphd_pkg::TYPE_VIRT) ||
                     ((ptype_reg == lphd_pkg::TYPE_SEQ) && seq_start_reg));
    assign is_cont = !is_long && !is_vhdr && (ptype_reg == lphd_pkg::TYPE_SEQ);

    // One shared decrement of the countdown
    always_comb begin
        if (phase_reg == lphd_pkg::PH_LONG) begin
            dec_amount = is_cont ? lphd_pkg::CONT_BYTES : lphd_pkg::VHDR_BYTES;
        end else begin
            dec_amount = lphd_pkg::ONE_BYTE;
        end
    end
    assign remaining_dec = remaining_reg - dec_amount;

    // Build the command and the next header state
    always_comb begin
        q_cmd.kind       = lphd_pkg::KIND_NONE;
        q_cmd.value      = 32'd0;
        q_cmd.packet_end = 1'b0;
        q_cmd.burst      = 1'b0;
        remaining_next   = remaining_reg;
        ptype_next       = ptype_reg;
        vsize_next       = vsize_reg;
        seq_start_next   = seq_start_reg;
        case (phase_reg)
            lphd_pkg::PH_SIZE: begin
                remaining_next = word32;
                q_cmd.kind     = lphd_pkg::KIND_RAW_SIZE;
                q_cmd.value    = word32;
            end
            lphd_pkg::PH_TYPE: begin
                ptype_next  = s_data_byte;
                q_cmd.kind  = lphd_pkg::KIND_RAW_TYPE;
                q_cmd.value = {24'd0, s_data_byte};
            end
            lphd_pkg::PH_SHORT: begin
                if (ptype_reg == lphd_pkg::TYPE_SHORT) begin
                    q_cmd.kind       = lphd_pkg::KIND_SHORT;
                    q_cmd.value      = word16;
                    q_cmd.packet_end = 1'b1;
                end
            end
            lphd_pkg::PH_LONG: begin
                if (is_long) begin
                    q_cmd.kind       = lphd_pkg::KIND_LONG;
                    q_cmd.value      = word32;
                    q_cmd.packet_end = 1'b1;
                end else if (is_vhdr) begin
                    vsize_next     = word32;
                    q_cmd.kind     = lphd_pkg::KIND_VSIZE;
                    q_cmd.value    = word32;
                    seq_start_next = (ptype_reg == lphd_pkg::TYPE_VIRT);
                    remaining_next = remaining_dec;
                end else if (is_cont) begin
                    q_cmd.kind       = lphd_pkg::KIND_PAYLOAD;
                    q_cmd.value      = word32;
                    q_cmd.burst      = 1'b1;
                    remaining_next   = remaining_dec;
                    q_cmd.packet_end = (remaining_dec == 32'd0);
                end
            end
            lphd_pkg::PH_VTYPE: begin
                q_cmd.kind       = lphd_pkg::KIND_VTYPE;
                q_cmd.value      = word16;
                q_cmd.packet_end = (vsize_reg == 32'd0);
            end
            lphd_pkg::PH_PAYLOAD: begin
                q_cmd.kind       = lphd_pkg::KIND_PAYLOAD;
                q_cmd.value      = {24'd0, s_data_byte};
                remaining_next   = remaining_dec;
                q_cmd.packet_end = (remaining_dec == 32'd0);
            end
            default: begin
            end
        endcase
    end

    // Advance the phase: restart on packet end, jump to payload after a burst
    always_comb begin
        if (q_cmd.packet_end) begin
            phase_next = lphd_pkg::PH_FIRST;
        end else if (q_cmd.burst || phase_reg >= lphd_pkg::PH_PAYLOAD) begin
            phase_next = lphd_pkg::PH_PAYLOAD;
        end else if (phase_reg == 4'd0) begin
            phase_next = lphd_pkg::PH_FIRST;
        end else begin
            phase_next = phase_reg + 4'd1;
        end
    end

    // Control and header state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lphd_pkg::PH_FIRST;
            remaining_reg <= 32'd0;
            ptype_reg     <= 8'd0;
            vsize_reg     <= 32'd0;
            seq_start_reg <= 1'b1;
        end else if (q_push) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            ptype_reg     <= ptype_next;
            vsize_reg     <= vsize_next;
            seq_start_reg <= seq_start_next;
        end
    end

    // Hold the last three header bytes
    always_ff @(posedge aclk) begin
        if (q_push) begin
            shift_reg <= {shift_reg[15:0], s_data_byte};
        end
    end

endmodule

`default_nettype wire

>>> src/lphd_queue.sv
// Short command queue between the front and back ends of the deframer.
// Flip-flop storage, one write (while not full) and one read (while not empty) per cycle. Depends on lphd_pkg.
`default_nettype none

module lphd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lphd_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output lphd_pkg::cmd_t       head_cmd
);

    lphd_pkg::cmd_t                 mem_reg [lphd_pkg::QUEUE_DEPTH];
    logic [lphd_pkg::QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [lphd_pkg::QUEUE_AW:0]    count_reg, count_next;

    assign full       = (count_reg == (lphd_pkg::QUEUE_AW+1)'(lphd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store requests
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("queue read while empty");

endmodule

`default_nettype wire

>>> src/lphd_back.sv
// Back end of the deframer: expands queued commands into results and holds
// them in an output register. Depends on lphd_pkg.
`default_nettype none

module lphd_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            head_valid,
    input  wire lphd_pkg::cmd_t  head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [2:0]           m_kind,
    output logic [31:0]          m_value,
    output logic                 m_packet_end,
    output logic                 m_last
);

    logic                m_valid_reg, m_valid_next;
    lphd_pkg::kind_t     kind_reg, kind_next;
    logic [31:0]         value_reg, value_next;
    logic                end_reg, end_next;
    logic                last_reg, last_next;
    logic [1:0]          sub_reg, sub_next;
    logic                load;
    logic                final_part;

    assign load       = head_valid && (!m_valid_reg || m_ready);
    assign final_part = !head_cmd.burst || (sub_reg == lphd_pkg::BURST_LAST);
    assign pop        = load && final_part;

    // Select the next result from the queue head
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        end_next     = end_reg;
        last_next    = last_reg;
        sub_next     = sub_reg;
        if (load) begin
            m_valid_next = 1'b1;
            kind_next    = head_cmd.kind;
            end_next     = head_cmd.packet_end && final_part;
            last_next    = final_part;
            if (head_cmd.burst) begin
                case (sub_reg)
                    2'd0:    value_next = {24'd0, head_cmd.value[31:24]};
                    2'd1:    value_next = {24'd0, head_cmd.value[23:16]};
                    2'd2:    value_next = {24'd0, head_cmd.value[15:8]};
                    default: value_next = {24'd0, head_cmd.value[7:0]};
                endcase
                sub_next = final_part ? 2'd0 : sub_reg + 2'd1;
            end else begin
                value_next = head_cmd.value;
                sub_next   = 2'd0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sub_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            sub_reg     <= sub_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_value      = value_reg;
    assign m_packet_end = end_reg;
    assign m_last       = last_reg;

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_packet_end) |-> m_last)
        else $error("packet end on a result that is not the last of its byte");

    a_burst_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (sub_reg != 2'd0) |-> (head_valid && head_cmd.burst))
        else $error("burst in progress without a burst command at the head");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == lphd_pkg::KIND_NONE)) |-> (m_value == 32'd0))
        else $error("empty result carries a nonzero value");

endmodule

`default_nettype wire

>>> src/link_packet_header_deframer.sv
// Link packet header deframer: takes one link byte per cycle while s_ready is
// high and returns, per byte, one result (four for the ninth byte of a
// continuation type 3 packet). The front end accepts a byte every cycle while
// its four-entry command queue has room; the back end emits one result per
// cycle from an output register while m_ready allows, so a continuation burst
// occupies it for four results and other bytes for one each. A byte's first
// result passes through the command queue and the output register before it
// is presented. Depends on lphd_pkg, lphd_front, lphd_queue and lphd_back.
`default_nettype none

module link_packet_header_deframer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_kind,
    output logic [31:0]       m_value,
    output logic              m_packet_end,
    output logic              m_last
);

    logic            q_full;
    logic            q_push;
    lphd_pkg::cmd_t  q_cmd;
    logic            q_pop;
    logic            head_valid;
    lphd_pkg::cmd_t  head_cmd;

    // Classify incoming bytes
    lphd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // Buffer requests between the two ends
    lphd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Expand requests into results
    lphd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_packet_end (m_packet_end),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
